/* rtl/thick_line_span_rasterizer_unit_assert.svh */
// Assertion macros shared by the thick line span rasterizer RTL.
`ifndef THICK_LINE_SPAN_RASTERIZER_UNIT_ASSERT_SVH
`define THICK_LINE_SPAN_RASTERIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define TLSR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlsr: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define TLSR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlsr: next-cycle check failed");
`else
`define TLSR_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLSR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/tlsr_pkg.sv */
// Package with shared constants and types of the thick line span rasterizer.
`default_nettype none
package tlsr_pkg;

   // Coordinate width of every column and row field.
   localparam int COORD_BITS = 11;

   // Default visible screen width in pixels.
   localparam int SCREEN_WIDTH_DEF = 480;

   // Field widths of the transaction payloads.
   localparam int THICK_BITS = 8;
   localparam int HALF_BITS  = THICK_BITS - 1;
   localparam int DATA_BITS  = 32;

   // Bresenham decision and increment widths.
   localparam int DEC_BITS  = COORD_BITS + 3;
   localparam int INCS_BITS = COORD_BITS + 2;

   // Operation codes of an input transaction.
   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

endpackage
`default_nettype wire

/* rtl/thick_line_span_rasterizer_unit.sv */
// A transaction's span is formed in stage one, from the line state written when it is
// accepted, and is then held in the result register, which drives the rsp_ ports.
// Throughput: one transaction per cycle unless rsp_ready is held low; the Bresenham step
// and the span clip, address multiply and add each take one register stage, so neither
// limits the rate. A span that waits in the result register lets one more transaction
// into stage one; then req_ready stays low until the span is taken.
// Reset (synchronous, active high) ends any line in progress and empties both stages.
`default_nettype none
`include "thick_line_span_rasterizer_unit_assert.svh"
module thick_line_span_rasterizer_unit #(
   parameter int SCREEN_WIDTH = tlsr_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [tlsr_pkg::COORD_BITS-1:0]   req_start_col,
   input  logic [tlsr_pkg::COORD_BITS-1:0]   req_start_row,
   input  logic [tlsr_pkg::COORD_BITS-1:0]   req_end_col,
   input  logic [tlsr_pkg::COORD_BITS-1:0]   req_end_row,
   input  logic [tlsr_pkg::THICK_BITS-1:0]   req_thickness,
   input  logic [tlsr_pkg::DATA_BITS-1:0]    req_pen_color,
   input  logic [tlsr_pkg::DATA_BITS-1:0]    req_layer_base,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_span_valid,
   output logic [tlsr_pkg::COORD_BITS-1:0]   rsp_span_row,
   output logic [tlsr_pkg::COORD_BITS-1:0]   rsp_span_left,
   output logic [tlsr_pkg::COORD_BITS-1:0]   rsp_span_right,
   output logic [tlsr_pkg::DATA_BITS-1:0]    rsp_pixel_address,
   output logic [tlsr_pkg::DATA_BITS-1:0]    rsp_span_color,
   output logic                              rsp_last_span
);
   import tlsr_pkg::*;

   localparam int SW_BITS   = $clog2(SCREEN_WIDTH + 1);
   localparam int PROD_BITS = COORD_BITS + SW_BITS;
   localparam logic [SW_BITS-1:0]    SW_K      = SW_BITS'(SCREEN_WIDTH);
   localparam logic [COORD_BITS:0]   RIGHT_MAX = (COORD_BITS + 1)'(SCREEN_WIDTH - 1);

   // Line state, written when a transaction is accepted.
   logic                        active_ff, active_in;
   logic [COORD_BITS-1:0]       cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0]       cur_row_ff, cur_row_in;
   logic [COORD_BITS-1:0]       goal_col_ff, goal_col_in;
   logic [COORD_BITS-1:0]       goal_row_ff, goal_row_in;
   logic                        col_neg_ff, col_neg_in;
   logic                        row_neg_ff, row_neg_in;
   logic                        steep_ff, steep_in;
   logic signed [DEC_BITS-1:0]  decision_ff, decision_in;
   logic [INCS_BITS-1:0]        inc_straight_ff, inc_straight_in;
   logic signed [DEC_BITS-1:0]  inc_diag_ff, inc_diag_in;
   logic [HALF_BITS-1:0]        half_ff, half_in;
   logic [DATA_BITS-1:0]        color_ff, color_in;
   logic [DATA_BITS-1:0]        base_ff, base_in;

   // Stage one: a transaction whose span is still to be formed from the line state.
   logic s1_valid_ff, s1_valid_in;
   logic s1_zero_ff, s1_zero_in;
   logic s1_last_ff, s1_last_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        span_valid_ff, span_valid_in;
   logic [COORD_BITS-1:0]       row_ff, row_in;
   logic [COORD_BITS-1:0]       left_ff, left_in;
   logic [COORD_BITS-1:0]       right_ff, right_in;
   logic [DATA_BITS-1:0]        addr_ff, addr_in;
   logic [DATA_BITS-1:0]        span_color_ff, span_color_in;
   logic                        last_ff, last_in;

   logic req_accept;
   logic s1_move;

   // Start decode.
   logic                        start_col_neg, start_row_neg, start_steep;
   logic [COORD_BITS-1:0]       dx, dy, major, minor;
   logic signed [DEC_BITS-1:0]  major_s, minor2_s;

   // Tick step.
   logic                        take_diag;
   logic [COORD_BITS-1:0]       col_step, row_step;
   logic signed [DEC_BITS-1:0]  dec_add;

   // Span forming.
   logic [COORD_BITS-1:0]       half_ext;
   logic [COORD_BITS-1:0]       span_left;
   logic [COORD_BITS:0]         right_sum;
   logic [COORD_BITS-1:0]       span_right;
   logic [PROD_BITS-1:0]        row_offset;
   logic [DATA_BITS-1:0]        pixel_index;

   // Handshake: stage one drains into the result register whenever it is free.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;

   // Endpoint decode for a start transaction.
   always_comb begin
      start_col_neg = !(req_start_col < req_end_col);
      start_row_neg = !(req_start_row < req_end_row);
      dx = start_col_neg ? req_start_col - req_end_col : req_end_col - req_start_col;
      dy = start_row_neg ? req_start_row - req_end_row : req_end_row - req_start_row;
      start_steep = !(dx > dy);
      major    = start_steep ? dy : dx;
      minor    = start_steep ? dx : dy;
      major_s  = signed'(DEC_BITS'(major));
      minor2_s = signed'(DEC_BITS'({minor, 1'b0}));
   end

   // One Bresenham step of the active line.
   always_comb begin
      take_diag = steep_ff ? (decision_ff >= 0) : (decision_ff > 0);
      col_step  = col_neg_ff ? cur_col_ff - 1'b1 : cur_col_ff + 1'b1;
      row_step  = row_neg_ff ? cur_row_ff - 1'b1 : cur_row_ff + 1'b1;
      dec_add   = take_diag ? inc_diag_ff : signed'(DEC_BITS'(inc_straight_ff));
   end

   // Next line state and stage-one flags.
   always_comb begin
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      goal_col_in     = goal_col_ff;
      goal_row_in     = goal_row_ff;
      col_neg_in      = col_neg_ff;
      row_neg_in      = row_neg_ff;
      steep_in        = steep_ff;
      decision_in     = decision_ff;
      inc_straight_in = inc_straight_ff;
      inc_diag_in     = inc_diag_ff;
      half_in         = half_ff;
      color_in        = color_ff;
      base_in         = base_ff;
      s1_zero_in      = 1'b0;
      if (req_op == OP_START) begin
         cur_col_in      = req_start_col;
         cur_row_in      = req_start_row;
         goal_col_in     = req_end_col;
         goal_row_in     = req_end_row;
         col_neg_in      = start_col_neg;
         row_neg_in      = start_row_neg;
         steep_in        = start_steep;
         inc_straight_in = INCS_BITS'({minor, 1'b0});
         inc_diag_in     = minor2_s - signed'(DEC_BITS'({major, 1'b0}));
         decision_in     = minor2_s - major_s;
         half_in         = req_thickness[THICK_BITS-1:1];
         color_in        = req_pen_color;
         base_in         = req_layer_base;
      end else if (active_ff) begin
         decision_in = decision_ff + dec_add;
         if (steep_ff) begin
            cur_row_in = row_step;
            if (take_diag) begin
               cur_col_in = col_step;
            end
         end else begin
            cur_col_in = col_step;
            if (take_diag) begin
               cur_row_in = row_step;
            end
         end
      end else begin
         s1_zero_in = 1'b1;
      end
      if (req_op == OP_START || active_ff) begin
         active_in = steep_in ? (cur_row_in != goal_row_in) : (cur_col_in != goal_col_in);
      end else begin
         active_in = 1'b0;
      end
      s1_last_in = !active_in;
   end

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (req_accept) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         goal_col_ff     <= goal_col_in;
         goal_row_ff     <= goal_row_in;
         col_neg_ff      <= col_neg_in;
         row_neg_ff      <= row_neg_in;
         steep_ff        <= steep_in;
         decision_ff     <= decision_in;
         inc_straight_ff <= inc_straight_in;
         inc_diag_ff     <= inc_diag_in;
         half_ff         <= half_in;
         color_ff        <= color_in;
         base_ff         <= base_in;
         s1_zero_ff      <= s1_zero_in;
         s1_last_ff      <= s1_last_in;
      end
   end

   // Stage-one occupancy.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Span clip and pixel address from the current point.
   always_comb begin
      half_ext    = COORD_BITS'(half_ff);
      span_left   = (cur_col_ff > half_ext) ? cur_col_ff - half_ext : '0;
      right_sum   = {1'b0, cur_col_ff} + {1'b0, half_ext};
      span_right  = (right_sum > RIGHT_MAX) ? RIGHT_MAX[COORD_BITS-1:0]
                                            : right_sum[COORD_BITS-1:0];
      row_offset  = PROD_BITS'(cur_row_ff) * PROD_BITS'(SW_K);
      pixel_index = DATA_BITS'(row_offset) + DATA_BITS'(span_left);
   end

   // Next result register contents.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      span_valid_in = span_valid_ff;
      row_in        = row_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      addr_in       = addr_ff;
      span_color_in = span_color_ff;
      last_in       = last_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         if (s1_zero_ff) begin
            span_valid_in = 1'b0;
            row_in        = '0;
            left_in       = '0;
            right_in      = '0;
            addr_in       = '0;
            span_color_in = '0;
            last_in       = 1'b0;
         end else begin
            span_valid_in = (span_left <= span_right);
            row_in        = cur_row_ff;
            left_in       = span_left;
            right_in      = span_right;
            addr_in       = base_ff + {pixel_index[DATA_BITS-3:0], 2'b00};
            span_color_in = color_ff;
            last_in       = s1_last_ff;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      span_valid_ff <= span_valid_in;
      row_ff        <= row_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      addr_ff       <= addr_in;
      span_color_ff <= span_color_in;
      last_ff       <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_span_valid    = span_valid_ff;
   assign rsp_span_row      = row_ff;
   assign rsp_span_left     = left_ff;
   assign rsp_span_right    = right_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_span_color    = span_color_ff;
   assign rsp_last_span     = last_ff;

   // A line only ends through an accepted transaction.
   `TLSR_ASSERT_IMP(a_end_by_txn, clock, reset, $fell(active_ff) && !$past(reset), $past(req_accept))
   // A tick with no line in progress yields an empty result.
   `TLSR_ASSERT_NXT(a_idle_tick, clock, reset, req_accept && req_op == OP_TICK && !active_ff, s1_valid_ff && s1_zero_ff)
   // The pending last flag matches the line state it was formed with.
   `TLSR_ASSERT_IMP(a_last_vs_active, clock, reset, s1_valid_ff && !s1_zero_ff, active_ff == !s1_last_ff)
   // An empty result never stands while a line is in progress.
   `TLSR_ASSERT_IMP(a_zero_idle, clock, reset, s1_valid_ff && s1_zero_ff, !active_ff)

endmodule
`default_nettype wire
